[src/sepq_pkg.sv]
// ----------------------------------------------------------------------------
// sepq_pkg
// types and codes shared by the sweep event queue and its cells
// ----------------------------------------------------------------------------
package sepq_pkg;

  localparam int EDGE_W  = 10;
  localparam int SITE_W  = 10;
  localparam int COORD_W = 32;
  localparam int OFF_W   = 31;
  localparam int CNT_W   = 7;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [1:0]        cell_op_t;

  localparam kind_t KIND_INSERT  = 2'd0;
  localparam kind_t KIND_DELETE  = 2'd1;
  localparam kind_t KIND_EXTRACT = 2'd2;
  localparam kind_t KIND_PEEK    = 2'd3;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_ABSENT = 3'd1;
  localparam status_t ST_EMPTY  = 3'd2;
  localparam status_t ST_FULL   = 3'd3;
  localparam status_t ST_DUP    = 3'd4;

  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_NEW  = 2'd1;
  localparam cell_op_t CELL_PREV = 2'd2;
  localparam cell_op_t CELL_NEXT = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] key_y;
    logic [COORD_W-1:0] key_x;
    logic [EDGE_W-1:0]  edge_id;
    logic [SITE_W-1:0]  site_id;
  } entry_t;

endpackage

[src/sepq_cell.sv]
// ----------------------------------------------------------------------------
// sepq_cell
// one slot of the sorted queue row: holds an entry, compares it with the
// pending word and takes its own, the new, the left or the right entry
// ----------------------------------------------------------------------------
module sepq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sepq_pkg::cell_op_t op,
  input  sepq_pkg::entry_t  new_e,
  input  sepq_pkg::entry_t  prev_e,
  input  sepq_pkg::entry_t  next_e,
  output sepq_pkg::entry_t  cur_e,
  output sepq_pkg::entry_t  cur_nxt,
  output logic              gt,
  output logic              hit
);
  import sepq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    case (op)
      CELL_NEW:  ent_nxt = new_e;
      CELL_PREV: ent_nxt = prev_e;
      CELL_NEXT: ent_nxt = next_e;
      default:   ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  // new word sorts after this entry
  assign gt = ent_r.valid &&
              (($signed(new_e.key_y) > $signed(ent_r.key_y)) ||
               ((new_e.key_y == ent_r.key_y) &&
                ($signed(new_e.key_x) > $signed(ent_r.key_x))));

  assign hit     = ent_r.valid && (ent_r.edge_id == new_e.edge_id);
  assign cur_e   = ent_r;
  assign cur_nxt = ent_nxt;

endmodule

[src/sweep_event_priority_queue.sv]
// ----------------------------------------------------------------------------
// sweep_event_priority_queue
// sorted priority queue of sweep events held in a row of cells, slot 0 the
// minimum; insert, delete by edge, extract and peek, one result per word
//
//   channel | dir | handshake                  | word
//   in_     | in  | in_tvalid / in_tready      | operation and event fields
//   out_    | out | out_tvalid / out_tready    | status, head entry, count
//
// each item first has its word registered and its key saturated, then the
// cell row inserts or closes the gap and the result register is loaded
// reset clears the cell valid bits and the count
// while the result register is full and not being read the row waits in its
// update state; a new word is taken only after the row has been updated
// ----------------------------------------------------------------------------
module sweep_event_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // edge_id[9:0] site_id[19:10] site_x[51:20] site_y[83:52] offset[114:84]
  input  logic [119:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // head_edge[9:0] head_site[19:10] head_key_y[51:20] head_key_x[83:52]
  // count[90:84] is_empty[91]
  output logic [95:0]  out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser
);
  import sepq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic          state_r, state_nxt;
  kind_t         kind_r;
  entry_t        op_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  status_t       out_status_r;
  entry_t        out_head_r;
  logic [CW-1:0] out_count_r;

  entry_t cell_q   [DEPTH];
  entry_t cell_nx  [DEPTH];
  entry_t prev_in  [DEPTH];
  entry_t next_in  [DEPTH];
  cell_op_t cell_op [DEPTH];
  logic [DEPTH-1:0] gt_vec, hit_vec, valid_vec, stay_prev, rm_vec, ge_vec;

  logic            fire, do_ins, do_rm, any_hit, is_full, is_zero;
  status_t         status;
  entry_t          head;
  logic signed [COORD_W:0] sum_y;
  logic [COORD_W-1:0]      key_y_sat;
  logic [CW+CNT_W-1:0]     count_ext;

  // ---------------- input capture
  assign in_tready = (state_r == S_IDLE);

  assign sum_y = {in_tdata[83], in_tdata[83:52]} + {2'b00, in_tdata[114:84]};
  assign key_y_sat = (!sum_y[COORD_W] && sum_y[COORD_W-1]) ?
                     {1'b0, {(COORD_W-1){1'b1}}} : sum_y[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r        <= in_tuser;
      op_r.valid    <= 1'b1;
      op_r.edge_id  <= in_tdata[9:0];
      op_r.site_id  <= in_tdata[19:10];
      op_r.key_x    <= in_tdata[51:20];
      op_r.key_y    <= key_y_sat;
    end
  end

  // ---------------- cell row
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign prev_in[g] = '0;
      end else begin : g_mid
        assign prev_in[g] = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign next_in[g] = '0;
      end else begin : g_inner
        assign next_in[g] = cell_q[g+1];
      end

      assign cell_op[g] = !fire ? CELL_HOLD :
                          do_ins ? (gt_vec[g]    ? CELL_HOLD :
                                    stay_prev[g] ? CELL_NEW  : CELL_PREV) :
                          (do_rm && ge_vec[g]) ? CELL_NEXT : CELL_HOLD;

      sepq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (cell_op[g]),
        .new_e   (op_r),
        .prev_e  (prev_in[g]),
        .next_e  (next_in[g]),
        .cur_e   (cell_q[g]),
        .cur_nxt (cell_nx[g]),
        .gt      (gt_vec[g]),
        .hit     (hit_vec[g])
      );

      assign valid_vec[g] = cell_q[g].valid;
    end
  endgenerate

  assign stay_prev = {gt_vec[DEPTH-2:0], 1'b1};
  assign ge_vec    = ~(rm_vec - DEPTH'(1));

  // ---------------- operation decode
  assign any_hit = |hit_vec;
  assign is_full = (count_r == CW'(DEPTH));
  assign is_zero = (count_r == '0);
  assign fire    = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    status = ST_OK;
    do_ins = 1'b0;
    do_rm  = 1'b0;
    rm_vec = DEPTH'(1);
    case (kind_r)
      KIND_INSERT: begin
        if (any_hit) begin
          status = ST_DUP;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (!any_hit) begin
          status = ST_ABSENT;
        end else begin
          do_rm  = 1'b1;
          rm_vec = hit_vec;
        end
      end
      KIND_EXTRACT: begin
        if (is_zero) begin
          status = ST_EMPTY;
        end else begin
          do_rm = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (is_zero) begin
          status = ST_EMPTY;
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rm) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    if (do_rm && (kind_r == KIND_EXTRACT)) begin
      head = cell_q[0];
    end else if (cell_nx[0].valid) begin
      head = cell_nx[0];
    end else begin
      head = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status;
      out_head_r   <= head;
      out_count_r  <= count_nxt;
    end
  end

  // ---------------- result word
  assign count_ext  = {{CNT_W{1'b0}}, out_count_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0000,
                       (out_count_r == '0),
                       count_ext[CNT_W-1:0],
                       out_head_r.key_x,
                       out_head_r.key_y,
                       out_head_r.site_id,
                       out_head_r.edge_id};

  // ---------------- checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("cell valid bits disagree with count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("valid cells not packed at the head");

  a_edge_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hit_vec))
    else $error("edge held in more than one cell");

endmodule

[dv/tb_sweep_event_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_sweep_event_priority_queue
// self-checking bench for the sweep event queue: a scoreboard keeps its own
// sorted event list and queued-edge flags, predicts the result word of every
// accepted operation and compares it field by field with what comes out;
// directed corner cases first, then random fill, drain and mixed phases with
// random idling, a long receiver hold-off and a full sender pause
// ----------------------------------------------------------------------------
module tb_sweep_event_priority_queue;
  import sepq_pkg::*;

  localparam int QDEPTH       = 64;
  localparam int EDGE_IDS     = 1024;
  localparam int N_RANDOM     = 1830;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RX_HOLD      = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;

  typedef struct {
    logic [EDGE_W-1:0] edge_id;
    logic [SITE_W-1:0] site_id;
    int                key_y;
    int                key_x;
  } sweep_ev_t;

  typedef struct {
    status_t           status;
    logic [EDGE_W-1:0] edge_id;
    logic [SITE_W-1:0] site_id;
    int                key_y;
    int                key_x;
    logic [CNT_W-1:0]  cnt;
    logic              empty;
  } head_report_t;

  class sweep_queue_scoreboard;
    sweep_ev_t    sorted_events[$];
    bit           edge_queued[EDGE_IDS];
    head_report_t awaiting_reports[$];
    int           errors;

    function head_report_t head_of(status_t st);
      head_report_t r;
      r.status = st;
      r.cnt    = CNT_W'(sorted_events.size());
      r.empty  = (sorted_events.size() == 0);
      if (r.empty) begin
        r.edge_id = '0;
        r.site_id = '0;
        r.key_y   = 0;
        r.key_x   = 0;
      end else begin
        r.edge_id = sorted_events[0].edge_id;
        r.site_id = sorted_events[0].site_id;
        r.key_y   = sorted_events[0].key_y;
        r.key_x   = sorted_events[0].key_x;
      end
      return r;
    endfunction

    function head_report_t predict_report(kind_t kind, logic [EDGE_W-1:0] edge_id,
                                          logic [SITE_W-1:0] site_id, int site_x,
                                          int site_y, logic [OFF_W-1:0] offset);
      sweep_ev_t    ev;
      head_report_t r;
      longint       sum;
      int           p;
      case (kind)
        KIND_INSERT: begin
          if (edge_queued[edge_id]) return head_of(ST_DUP);
          if (sorted_events.size() >= QDEPTH) return head_of(ST_FULL);
          sum = longint'(site_y) + longint'({1'b0, offset});
          ev.edge_id = edge_id;
          ev.site_id = site_id;
          ev.key_x   = site_x;
          ev.key_y   = (sum > 64'sd2147483647) ? 32'h7fffffff : int'(sum);
          // newest goes ahead of equal keys
          p = 0;
          while (p < sorted_events.size() &&
                 (ev.key_y > sorted_events[p].key_y ||
                  (ev.key_y == sorted_events[p].key_y &&
                   ev.key_x > sorted_events[p].key_x)))
            p++;
          sorted_events.insert(p, ev);
          edge_queued[edge_id] = 1'b1;
          return head_of(ST_OK);
        end
        KIND_DELETE: begin
          if (!edge_queued[edge_id]) return head_of(ST_ABSENT);
          for (p = 0; p < sorted_events.size(); p++)
            if (sorted_events[p].edge_id == edge_id) break;
          if (p < sorted_events.size()) sorted_events.delete(p);
          edge_queued[edge_id] = 1'b0;
          return head_of(ST_OK);
        end
        default: begin
          if (sorted_events.size() == 0) return head_of(ST_EMPTY);
          if (kind == KIND_EXTRACT) begin
            ev = sorted_events.pop_front();
            edge_queued[ev.edge_id] = 1'b0;
            r = head_of(ST_OK);
            r.edge_id = ev.edge_id;
            r.site_id = ev.site_id;
            r.key_y   = ev.key_y;
            r.key_x   = ev.key_x;
            return r;
          end
          return head_of(ST_OK);
        end
      endcase
    endfunction

    function void note_word(kind_t kind, logic [EDGE_W-1:0] edge_id,
                            logic [SITE_W-1:0] site_id, int site_x, int site_y,
                            logic [OFF_W-1:0] offset);
      awaiting_reports.push_back(predict_report(kind, edge_id, site_id, site_x, site_y,
                                                offset));
    endfunction

    function void check_report(logic [95:0] data, logic [2:0] user);
      head_report_t want;
      bit           bad;
      if (awaiting_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result word: tuser %0d tdata %h", user, data);
        return;
      end
      want = awaiting_reports.pop_front();
      bad = (user !== want.status) || (data[9:0] !== want.edge_id) ||
            (data[19:10] !== want.site_id) || (data[51:20] !== want.key_y) ||
            (data[83:52] !== want.key_x) || (data[90:84] !== want.cnt) ||
            (data[91] !== want.empty);
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: expected status %0d edge %0d site %0d %s",
                   want.status, want.edge_id, want.site_id,
                   $sformatf("key_y %h key_x %h cnt %0d empty %0d",
                             want.key_y, want.key_x, want.cnt, want.empty));
          $display("          actual   status %0d edge %0d site %0d %s",
                   user, data[9:0], data[19:10],
                   $sformatf("key_y %h key_x %h cnt %0d empty %0d",
                             data[51:20], data[83:52], data[90:84], data[91]));
        end
      end
    endfunction

    function int pending();
      return awaiting_reports.size();
    endfunction

    function logic [EDGE_W-1:0] pick_queued_edge();
      if (sorted_events.size() == 0) return EDGE_W'($urandom_range(EDGE_IDS-1));
      return sorted_events[$urandom_range(sorted_events.size()-1)].edge_id;
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [2:0]   out_tuser;

  bit quiet;
  bit rx_hold_go;

  sweep_queue_scoreboard sb;

  sweep_event_priority_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(kind_t kind, logic [EDGE_W-1:0] edge_id,
                           logic [SITE_W-1:0] site_id, int site_x, int site_y,
                           logic [OFF_W-1:0] offset);
    in_tuser  <= kind;
    in_tdata  <= {5'b0, offset, site_y, site_x, site_id, edge_id};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_word(kind, edge_id, site_id, site_x, site_y, offset);
    if (!quiet && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic int rand_coord();
    case ($urandom_range(9))
      0, 1, 2: return (int'($urandom_range(4)) - 2) <<< 16;
      3:       return 32'h7fffffff;
      4:       return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] rand_offset();
    case ($urandom_range(9))
      0, 1, 2, 3: return '0;
      4, 5:       return OFF_W'($urandom_range(3)) << 16;
      6:          return 31'h7fffffff;
      default:    return OFF_W'($urandom);
    endcase
  endfunction

  task automatic random_word(int mode);
    int                r;
    kind_t             kind;
    logic [EDGE_W-1:0] edge_id;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL:  kind = (r < 75) ? KIND_INSERT : (r < 85) ? KIND_DELETE :
                         (r < 95) ? KIND_EXTRACT : KIND_PEEK;
      MODE_DRAIN: kind = (r < 15) ? KIND_INSERT : (r < 30) ? KIND_DELETE :
                         (r < 90) ? KIND_EXTRACT : KIND_PEEK;
      default:    kind = (r < 40) ? KIND_INSERT : (r < 60) ? KIND_DELETE :
                         (r < 85) ? KIND_EXTRACT : KIND_PEEK;
    endcase
    edge_id = EDGE_W'($urandom_range(EDGE_IDS-1));
    if (kind == KIND_INSERT && $urandom_range(99) < 12) edge_id = sb.pick_queued_edge();
    if (kind == KIND_DELETE && $urandom_range(99) < 70) edge_id = sb.pick_queued_edge();
    send_word(kind, edge_id, SITE_W'($urandom_range(1023)), rand_coord(), rand_coord(),
              rand_offset());
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata, out_tuser);
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        hold_left  = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 10) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL sweep_event_priority_queue");
    $finish;
  end

  initial begin
    int mode;
    sb         = new();
    quiet      = 1'b0;
    rx_hold_go = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= KIND_INSERT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, absent edge
    send_word(KIND_PEEK,    10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_EXTRACT, 10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_DELETE,  10'd0,   10'd0,   0, 0, '0);
    // extremes, key saturation and a duplicate edge
    send_word(KIND_INSERT,  10'd1023, 10'd1023, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    send_word(KIND_INSERT,  10'd0,   10'd0,   32'h80000000, 32'h80000000, '0);
    send_word(KIND_INSERT,  10'd0,   10'd5,   0, 0, '0);
    // equal keys, newest first, then x tie-break
    send_word(KIND_INSERT,  10'd5,   10'd50,  0, 0, '0);
    send_word(KIND_INSERT,  10'd6,   10'd60,  0, 0, '0);
    send_word(KIND_INSERT,  10'd7,   10'd70,  32'h00010000, 0, '0);
    send_word(KIND_INSERT,  10'd8,   10'd80,  -1, 32'hfffe0000, 31'h00020000);
    send_word(KIND_INSERT,  10'd9,   10'd90,  0, 32'h7fff0000, 31'h00020000);
    send_word(KIND_PEEK,    10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_DELETE,  10'd5,   10'd0,   0, 0, '0);
    send_word(KIND_DELETE,  10'd5,   10'd0,   0, 0, '0);
    send_word(KIND_EXTRACT, 10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_EXTRACT, 10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_DELETE,  10'd1023, 10'd0,  0, 0, '0);
    send_word(KIND_EXTRACT, 10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_EXTRACT, 10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_EXTRACT, 10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_EXTRACT, 10'd0,   10'd0,   0, 0, '0);
    send_word(KIND_PEEK,    10'd0,   10'd0,   0, 0, '0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) rx_hold_go = 1'b1;
      if (i == 600) quiet = 1'b1;
      if (i == 900) quiet = 1'b0;
      if (i == 1200) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      case ((i / 150) % 4)
        0:       mode = MODE_FILL;
        2:       mode = MODE_DRAIN;
        default: mode = MODE_MIXED;
      endcase
      random_word(mode);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS sweep_event_priority_queue");
    else
      $display("FAIL sweep_event_priority_queue");
    $finish;
  end

endmodule

[sim.f]
src/sepq_pkg.sv
src/sepq_cell.sv
src/sweep_event_priority_queue.sv
dv/tb_sweep_event_priority_queue.sv
